[hdl/hcib_pkg.sv]
// Shared types, codes and widths for the hit charge image binner.
// No dependencies; imported by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package hcib_pkg;

    // Default image size
    localparam int IMG_WIDTH  = 256;
    localparam int IMG_HEIGHT = 256;

    // Field widths
    localparam int POS_W    = 24;   // signed position, 1/256 cm
    localparam int STEP_W   = 16;   // padding step, 1/256 cm
    localparam int CHG_W    = 24;   // hit charge
    localparam int SUM_W    = 32;   // pixel sum
    localparam int RIDX_W   = 8;    // read row/col index
    localparam int PADDR_W  = 5;    // byte address of the register file
    localparam int PDATA_W  = 32;
    localparam int CALC_W   = 28;   // signed span and offset arithmetic
    localparam int DEN_W    = 26;   // twice the span, known positive

    // Register indexes
    localparam logic [2:0] REG_DRIFT_LOW  = 3'd0;
    localparam logic [2:0] REG_DRIFT_HIGH = 3'd1;
    localparam logic [2:0] REG_WIRE_LOW   = 3'd2;
    localparam logic [2:0] REG_WIRE_HIGH  = 3'd3;
    localparam logic [2:0] REG_DRIFT_STEP = 3'd4;
    localparam logic [2:0] REG_WIRE_PITCH = 3'd5;
    localparam logic [2:0] REG_FILTER     = 3'd6;

    // Register reset values
    localparam logic signed [POS_W-1:0] RST_DRIFT_LOW  = 24'sd0;
    localparam logic signed [POS_W-1:0] RST_DRIFT_HIGH = 24'sd65536;
    localparam logic signed [POS_W-1:0] RST_WIRE_LOW   = 24'sd0;
    localparam logic signed [POS_W-1:0] RST_WIRE_HIGH  = 24'sd262144;
    localparam logic [STEP_W-1:0]       RST_DRIFT_STEP = 16'd128;
    localparam logic [STEP_W-1:0]       RST_WIRE_PITCH = 16'd119;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ACC   = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_UPDATE,
        ST_FINISH
    } state_t;

endpackage

[hdl/hcib_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hcib_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/hcib_div.sv]
// Shift-subtract bin index unit: quotient of (off * size) / den, one bit a cycle.
// Depends on hcib_pkg; caller guarantees off < den.
`timescale 1ns / 1ps

module hcib_div
    import hcib_pkg::*;
#(
    parameter int QW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [DEN_W-1:0] off,
    input  logic [DEN_W-1:0] den,
    input  logic [QW:0]      size,
    output logic             done,
    output logic [QW-1:0]    quot
);

    localparam int NUM_W = DEN_W + QW;
    localparam int CNT_W = $clog2(QW + 1);

    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] dsh_reg, dsh_next;
    logic [QW-1:0]    q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic             ge;

    assign ge = (rem_reg >= dsh_reg);

    // Load the scaled offset, then take one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (load)
        begin
            rem_next = NUM_W'(off) * NUM_W'(size);
            dsh_next = NUM_W'(den) << (QW - 1);
            q_next   = '0;
            cnt_next = CNT_W'(QW - 1);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = QW'({q_reg, ge});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath needs no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[hdl/hit_charge_image_binner_top.sv]
// Top level of the hit charge image binner: command port, register file,
// sequencer and image memory. Depends on hcib_pkg, hcib_div and hcib_ram.
`timescale 1ns / 1ps

// Usage
//   Command channel: a command transfer happens at a rising edge with start
//   high and busy low. operation selects clear, accumulate or read.
//   Every command produces one result, shown for one cycle with done high;
//   the receiver cannot stall, so it must take the result in that cycle.
//   The user must write registers over the APB port only while busy is low; the block does not enforce this.
// Sequence
//   Accumulate: the bin indexes come from one shared shift-subtract unit, one
//     quotient bit a cycle, run once for the drift axis and once for the wire
//     axis, then a read-modify-write of the image memory. A hit that fails a
//     range check or the filter is dropped and leaves the memory unchanged.
//   Read: states ADDR, READ, UPDATE, FINISH. Undefined operation code: straight to FINISH.
//   Clear: the sweep writes one pixel a cycle over the whole image.
//   busy drops in the cycle that shows done, so a new command can follow.
// Reset
//   Registers return to their defaults, then a clearing pass over every
//   pixel zeroes the image with busy high and no result.
//   Register writes are taken during that pass.
module hit_charge_image_binner_top
    import hcib_pkg::*;
#(
    parameter int WIDTH  = IMG_WIDTH,
    parameter int HEIGHT = IMG_HEIGHT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    // command
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               operation,
    input  logic signed [POS_W-1:0]  hit_drift,
    input  logic signed [POS_W-1:0]  hit_zpos,
    input  logic [CHG_W-1:0]         hit_charge,
    input  logic [RIDX_W-1:0]        read_row,
    input  logic [RIDX_W-1:0]        read_col,
    // result
    output logic                     done,
    output logic [SUM_W-1:0]         pixel_sum,
    output logic                     pixel_nonzero,
    output logic                     hit_dropped
);

    localparam int COL_W  = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam int ROW_W  = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
    localparam int QW     = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DEPTH  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    // Register file
    logic signed [POS_W-1:0] drift_low_reg, drift_high_reg;
    logic signed [POS_W-1:0] wire_low_reg, wire_high_reg;
    logic [STEP_W-1:0]       drift_step_reg, wire_pitch_reg;
    logic                    filter_reg;
    logic                    wr_en;
    logic [2:0]              reg_idx;

    // Sequencer and datapath
    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic signed [POS_W-1:0] x_reg, x_next;
    logic signed [POS_W-1:0] z_reg, z_next;
    logic [CHG_W-1:0]        chg_reg, chg_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic                    axis_reg, axis_next;
    logic                    bad_reg, bad_next;
    logic [DEN_W-1:0]        off_reg, off_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic                    clr_op_reg, clr_op_next;
    logic                    done_reg, done_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic                    nz_reg, nz_next;
    logic                    drop_reg, drop_next;

    logic                    accept;
    logic                    read_ok;
    logic                    clear_last;
    logic signed [POS_W-1:0] pos_sel, low_sel, high_sel;
    logic [STEP_W-1:0]       step_sel;
    logic signed [CALC_W-1:0] span_c, diff_c, off2_c, dbl_c;
    logic                    bad_c, filt_c;
    logic [SUM_W:0]          acc_c;
    logic [SUM_W-1:0]        sat_c;

    logic                    ram_we;
    logic [SUM_W-1:0]        ram_wdata;
    logic [SUM_W-1:0]        ram_rdata;
    logic                    div_load;
    logic                    div_done;
    logic [QW-1:0]           div_quot;
    logic [QW:0]             div_size;

    // Register port: write on the access cycle, read combinationally
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drift_low_reg  <= RST_DRIFT_LOW;
            drift_high_reg <= RST_DRIFT_HIGH;
            wire_low_reg   <= RST_WIRE_LOW;
            wire_high_reg  <= RST_WIRE_HIGH;
            drift_step_reg <= RST_DRIFT_STEP;
            wire_pitch_reg <= RST_WIRE_PITCH;
            filter_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DRIFT_LOW:  drift_low_reg  <= pwdata[POS_W-1:0];
                REG_DRIFT_HIGH: drift_high_reg <= pwdata[POS_W-1:0];
                REG_WIRE_LOW:   wire_low_reg   <= pwdata[POS_W-1:0];
                REG_WIRE_HIGH:  wire_high_reg  <= pwdata[POS_W-1:0];
                REG_DRIFT_STEP: drift_step_reg <= pwdata[STEP_W-1:0];
                REG_WIRE_PITCH: wire_pitch_reg <= pwdata[STEP_W-1:0];
                REG_FILTER:     filter_reg     <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_DRIFT_LOW:  prdata = PDATA_W'(drift_low_reg);
            REG_DRIFT_HIGH: prdata = PDATA_W'(drift_high_reg);
            REG_WIRE_LOW:   prdata = PDATA_W'(wire_low_reg);
            REG_WIRE_HIGH:  prdata = PDATA_W'(wire_high_reg);
            REG_DRIFT_STEP: prdata = PDATA_W'(drift_step_reg);
            REG_WIRE_PITCH: prdata = PDATA_W'(wire_pitch_reg);
            REG_FILTER:     prdata = PDATA_W'(filter_reg);
            default:        prdata = '0;
        endcase
    end

    // Command handshake and read range check
    assign accept     = start && (state_reg == ST_IDLE);
    assign read_ok    = (32'(read_row) < HEIGHT) && (32'(read_col) < WIDTH);
    assign clear_last = (addr_reg == ADDR_W'(DEPTH - 1));

    // Axis setup: span, doubled offset and range checks for the current axis
    assign pos_sel  = axis_reg ? z_reg : x_reg;
    assign low_sel  = axis_reg ? wire_low_reg : drift_low_reg;
    assign high_sel = axis_reg ? wire_high_reg : drift_high_reg;
    assign step_sel = axis_reg ? wire_pitch_reg : drift_step_reg;

    assign span_c = CALC_W'(high_sel) - CALC_W'(low_sel) + CALC_W'(step_sel);
    assign diff_c = CALC_W'(pos_sel) - CALC_W'(low_sel);
    assign off2_c = CALC_W'({diff_c, 1'b0}) + CALC_W'(step_sel);
    assign dbl_c  = CALC_W'({span_c, 1'b0});
    assign bad_c  = (span_c <= 0) || (off2_c < 0) || (off2_c >= dbl_c);
    assign filt_c = filter_reg &&
                    ((x_reg < drift_low_reg) || (x_reg > drift_high_reg) ||
                     (z_reg > wire_high_reg));

    // Saturating accumulate
    assign acc_c = {1'b0, ram_rdata} + (SUM_W + 1)'(chg_reg);
    assign sat_c = acc_c[SUM_W] ? '1 : acc_c[SUM_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = clr_op_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(operation))
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_ACC:   state_next = ST_SETUP;
                        OP_READ:  state_next = read_ok ? ST_ADDR : ST_FINISH;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SETUP:  state_next = ST_LOAD;
            ST_LOAD:   state_next = bad_reg ? ST_FINISH : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = axis_reg ? ST_ADDR : ST_SETUP;
                end
            end
            ST_ADDR:   state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_FINISH;
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath register updates
    always_comb
    begin
        op_next     = op_reg;
        x_next      = x_reg;
        z_next      = z_reg;
        chg_next    = chg_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        axis_next   = axis_reg;
        bad_next    = bad_reg;
        off_next    = off_reg;
        den_next    = den_reg;
        addr_next   = addr_reg;
        clr_op_next = clr_op_reg;
        sum_next    = sum_reg;
        nz_next     = nz_reg;
        drop_next   = drop_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_t'(operation);
                    x_next      = hit_drift;
                    z_next      = hit_zpos;
                    chg_next    = hit_charge;
                    row_next    = ROW_W'(read_row);
                    col_next    = COL_W'(read_col);
                    axis_next   = 1'b0;
                    addr_next   = '0;
                    clr_op_next = 1'b1;
                    sum_next    = '0;
                    nz_next     = 1'b0;
                    drop_next   = 1'b0;
                end
            end
            ST_SETUP:
            begin
                off_next = off2_c[DEN_W-1:0];
                den_next = dbl_c[DEN_W-1:0];
                bad_next = axis_reg ? bad_c : (bad_c || filt_c);
            end
            ST_LOAD:
            begin
                if (bad_reg)
                begin
                    drop_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (axis_reg)
                    begin
                        row_next = ROW_W'(div_quot);
                    end
                    else
                    begin
                        col_next  = COL_W'(div_quot);
                        axis_next = 1'b1;
                    end
                end
            end
            ST_ADDR:
            begin
                addr_next = ADDR_W'(row_reg * WIDTH) + ADDR_W'(col_reg);
            end
            ST_UPDATE:
            begin
                if (op_reg == OP_READ)
                begin
                    sum_next = ram_rdata;
                    nz_next  = |ram_rdata;
                end
            end
            ST_READ, ST_FINISH: ;
            default: ;
        endcase
    end

    // Control outputs of the sequencer
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        done_next = (state_reg == ST_FINISH);
        div_load  = (state_reg == ST_LOAD) && !bad_reg;
        div_size  = axis_reg ? (QW + 1)'(HEIGHT) : (QW + 1)'(WIDTH);
        ram_we    = (state_reg == ST_CLEAR) ||
                    ((state_reg == ST_UPDATE) && (op_reg == OP_ACC));
        ram_wdata = (state_reg == ST_CLEAR) ? '0 : sat_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            clr_op_reg <= 1'b0;
            done_reg   <= 1'b0;
            axis_reg   <= 1'b0;
            bad_reg    <= 1'b0;
            op_reg     <= OP_NONE;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            clr_op_reg <= clr_op_next;
            done_reg   <= done_next;
            axis_reg   <= axis_next;
            bad_reg    <= bad_next;
            op_reg     <= op_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        z_reg    <= z_next;
        chg_reg  <= chg_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        off_reg  <= off_next;
        den_reg  <= den_next;
        sum_reg  <= sum_next;
        nz_reg   <= nz_next;
        drop_reg <= drop_next;
    end

    assign done          = done_reg;
    assign pixel_sum     = sum_reg;
    assign pixel_nonzero = nz_reg;
    assign hit_dropped   = drop_reg;

    // Shared bin index unit
    hcib_div #(
        .QW (QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (div_load),
        .off   (off_reg),
        .den   (den_reg),
        .size  (div_size),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Charge image
    hcib_ram #(
        .DATA_W (SUM_W),
        .DEPTH  (DEPTH)
    ) u_image (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

`ifndef SYNTH
    // A command transfer always leaves the idle state
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after command transfer");

    // The result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Nonzero flag agrees with the sum
    a_nonzero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && pixel_nonzero) |-> (pixel_sum != '0))
        else $error("nonzero flag with zero sum");

    // A dropped hit reports no pixel
    a_drop_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_dropped) |-> (pixel_sum == '0) && !pixel_nonzero)
        else $error("dropped hit carries a pixel value");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the hit charge image binner: directed and random commands,
// register settings over APB, and a scoreboard that predicts every pixel sum.
// Depends on hcib_pkg and hit_charge_image_binner_top.
`timescale 1ns / 1ps

module testbench;
    import hcib_pkg::*;

    localparam int NUM_PIXELS = IMG_WIDTH * IMG_HEIGHT;

    // One expected result: read sum, nonzero flag, dropped flag
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             nonzero;
        logic             dropped;
    } outcome_t;

    // Charge image predictor and result checker
    class charge_image_scoreboard;
        logic [SUM_W-1:0] charge_sums [NUM_PIXELS];
        outcome_t         pixel_outcomes [$];
        int               touched [$];
        longint           drift_lo, drift_hi, wire_lo, wire_hi, drift_pad, wire_pad;
        bit               filter_on;
        int               n_fail, n_clear, n_acc, n_drop, n_read, n_nonzero, n_other;

        function new();
            drift_lo  = longint'(RST_DRIFT_LOW);
            drift_hi  = longint'(RST_DRIFT_HIGH);
            wire_lo   = longint'(RST_WIRE_LOW);
            wire_hi   = longint'(RST_WIRE_HIGH);
            drift_pad = longint'(RST_DRIFT_STEP);
            wire_pad  = longint'(RST_WIRE_PITCH);
            filter_on = 1'b0;
            foreach (charge_sums[k])
                charge_sums[k] = '0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] val);
            case (idx)
                REG_DRIFT_LOW:  drift_lo  = longint'($signed(val[POS_W-1:0]));
                REG_DRIFT_HIGH: drift_hi  = longint'($signed(val[POS_W-1:0]));
                REG_WIRE_LOW:   wire_lo   = longint'($signed(val[POS_W-1:0]));
                REG_WIRE_HIGH:  wire_hi   = longint'($signed(val[POS_W-1:0]));
                REG_DRIFT_STEP: drift_pad = longint'(val[STEP_W-1:0]);
                REG_WIRE_PITCH: wire_pad  = longint'(val[STEP_W-1:0]);
                REG_FILTER:     filter_on = val[0];
                default: ;
            endcase
        endfunction

        // Bin index along one axis, or -1 when the hit misses the axis
        function longint bin_for(longint pos, longint lo, longint hi, longint pad,
                                 longint size);
            longint span, off2, idx;
            span = hi - lo + pad;
            off2 = 2 * (pos - lo) + pad;
            if (span <= 0 || off2 < 0)
                return -1;
            idx = (off2 * size) / (2 * span);
            return (idx >= size) ? -1 : idx;
        endfunction

        // Apply one accepted command to the image and queue its result
        function void take_command(op_t op, logic signed [POS_W-1:0] d,
                                   logic signed [POS_W-1:0] w, logic [CHG_W-1:0] q,
                                   logic [RIDX_W-1:0] r, logic [RIDX_W-1:0] c);
            longint   x, z, col, row;
            logic [SUM_W:0] acc;
            int       key;
            outcome_t res;
            res = '0;
            x = d;
            z = w;
            case (op)
                OP_CLEAR: begin
                    foreach (charge_sums[k])
                        charge_sums[k] = '0;
                    touched.delete();
                    n_clear++;
                end
                OP_ACC: begin
                    n_acc++;
                    if (filter_on && (x < drift_lo || x > drift_hi || z > wire_hi)) begin
                        res.dropped = 1'b1;
                    end
                    else begin
                        col = bin_for(x, drift_lo, drift_hi, drift_pad, IMG_WIDTH);
                        row = bin_for(z, wire_lo, wire_hi, wire_pad, IMG_HEIGHT);
                        if (col < 0 || row < 0) begin
                            res.dropped = 1'b1;
                        end
                        else begin
                            key = int'(row) * IMG_WIDTH + int'(col);
                            acc = {1'b0, charge_sums[key]} + q;
                            // saturate at the top of the sum range
                            charge_sums[key] = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
                            touched.insert(touched.size(), key);
                            if (touched.size() > 64)
                                void'(touched.pop_front());
                        end
                    end
                    if (res.dropped)
                        n_drop++;
                end
                OP_READ: begin
                    n_read++;
                    if (int'(r) < IMG_HEIGHT && int'(c) < IMG_WIDTH) begin
                        res.sum     = charge_sums[int'(r) * IMG_WIDTH + int'(c)];
                        res.nonzero = (res.sum != '0);
                    end
                    if (res.nonzero)
                        n_nonzero++;
                end
                default: n_other++;
            endcase
            pixel_outcomes.insert(pixel_outcomes.size(), res);
        endfunction

        function void check_result(logic [SUM_W-1:0] sum, logic nonzero, logic dropped);
            outcome_t exp_res;
            if (pixel_outcomes.size() == 0) begin
                $error("result with no command pending: pixel_sum %0d", sum);
                n_fail++;
                return;
            end
            exp_res = pixel_outcomes.pop_front();
            if (sum !== exp_res.sum) begin
                $error("pixel_sum: expected %0d, got %0d", exp_res.sum, sum);
                n_fail++;
            end
            if (nonzero !== exp_res.nonzero) begin
                $error("pixel_nonzero: expected %0b, got %0b", exp_res.nonzero, nonzero);
                n_fail++;
            end
            if (dropped !== exp_res.dropped) begin
                $error("hit_dropped: expected %0b, got %0b", exp_res.dropped, dropped);
                n_fail++;
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    psel, penable, pwrite;
    logic [PADDR_W-1:0]      paddr;
    logic [PDATA_W-1:0]      pwdata;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    start;
    logic                    busy;
    logic [1:0]              operation;
    logic signed [POS_W-1:0] hit_drift, hit_zpos;
    logic [CHG_W-1:0]        hit_charge;
    logic [RIDX_W-1:0]       read_row, read_col;
    logic                    done;
    logic [SUM_W-1:0]        pixel_sum;
    logic                    pixel_nonzero;
    logic                    hit_dropped;

    charge_image_scoreboard sb;

    hit_charge_image_binner_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .hit_drift     (hit_drift),
        .hit_zpos      (hit_zpos),
        .hit_charge    (hit_charge),
        .read_row      (read_row),
        .read_col      (read_col),
        .done          (done),
        .pixel_sum     (pixel_sum),
        .pixel_nonzero (pixel_nonzero),
        .hit_dropped   (hit_dropped)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Check results and record command transfers at each edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if (done === 1'b1)
                sb.check_result(pixel_sum, pixel_nonzero, hit_dropped);
            if (start === 1'b1 && busy === 1'b0)
                sb.take_command(op_t'(operation), hit_drift, hit_zpos, hit_charge,
                                read_row, read_col);
        end
    end

    // Drive one command and hold it until the transfer edge
    task automatic issue(input op_t op, input logic [POS_W-1:0] d, input logic [POS_W-1:0] w,
                         input logic [CHG_W-1:0] q, input logic [RIDX_W-1:0] r,
                         input logic [RIDX_W-1:0] c);
        start      <= 1'b1;
        operation  <= op;
        hit_drift  <= d;
        hit_zpos   <= w;
        hit_charge <= q;
        read_row   <= r;
        read_col   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and wait until every pending result has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pixel_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then an idle cycle
    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic set_region(input logic [PDATA_W-1:0] dl, input logic [PDATA_W-1:0] dh,
                              input logic [PDATA_W-1:0] wl, input logic [PDATA_W-1:0] wh,
                              input logic [PDATA_W-1:0] ds, input logic [PDATA_W-1:0] wp,
                              input logic [PDATA_W-1:0] flt);
        write_reg(REG_DRIFT_LOW, dl);
        write_reg(REG_DRIFT_HIGH, dh);
        write_reg(REG_WIRE_LOW, wl);
        write_reg(REG_WIRE_HIGH, wh);
        write_reg(REG_DRIFT_STEP, ds);
        write_reg(REG_WIRE_PITCH, wp);
        write_reg(REG_FILTER, flt);
    endtask

    // Position biased toward bin edges and filter limits of one axis
    function automatic logic [POS_W-1:0] pick_pos(longint lo, longint hi, longint pad);
        longint span, base, pos;
        logic [POS_W-1:0] raw;
        base = lo - pad / 2;
        span = hi - lo + pad;
        raw  = POS_W'($urandom);
        case ($urandom_range(0, 9))
            0: pos = longint'($signed(raw));
            1: pos = base + longint'(int'($urandom_range(0, 6))) - 3;
            2: pos = hi + pad / 2 + longint'(int'($urandom_range(0, 6))) - 3;
            3: pos = ($urandom_range(0, 1) ? lo : hi) + longint'(int'($urandom_range(0, 2))) - 1;
            default: pos = (span > 0) ? base + longint'($urandom) % span : lo;
        endcase
        return pos[POS_W-1:0];
    endfunction

    function automatic logic [CHG_W-1:0] pick_charge();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return CHG_W'($urandom);
        endcase
    endfunction

    // One random command; reads mostly target recently filled pixels
    task automatic random_cmd(input int idle_pct);
        int                pick, key;
        op_t               op;
        logic [RIDX_W-1:0] r, c;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            op = OP_NONE;
        else if (pick < 60)
            op = OP_ACC;
        else
            op = OP_READ;
        r    = RIDX_W'($urandom);
        c    = RIDX_W'($urandom);
        if (op == OP_READ && sb.touched.size() != 0 && $urandom_range(0, 9) < 6) begin
            key = sb.touched[$urandom_range(0, sb.touched.size() - 1)];
            r   = RIDX_W'(key / IMG_WIDTH);
            c   = RIDX_W'(key % IMG_WIDTH);
        end
        issue(op, pick_pos(sb.drift_lo, sb.drift_hi, sb.drift_pad),
              pick_pos(sb.wire_lo, sb.wire_hi, sb.wire_pad), pick_charge(), r, c);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            idle_for($urandom_range(1, 6));
    endtask

    task automatic run_random(input int n, input int idle_pct);
        repeat (n) random_cmd(idle_pct);
    endtask

    // Hammer one pixel with full charge until it saturates, then read it back
    task automatic saturate_pixel();
        logic [POS_W-1:0] d, w;
        int               key;
        d = POS_W'($urandom_range(0, 65535));
        w = POS_W'($urandom_range(0, 262143));
        repeat (258)
            issue(OP_ACC, d, w, '1, RIDX_W'($urandom), RIDX_W'($urandom));
        key = sb.touched[$];
        issue(OP_READ, POS_W'($urandom), POS_W'($urandom), CHG_W'($urandom),
              RIDX_W'(key / IMG_WIDTH), RIDX_W'(key % IMG_WIDTH));
        issue(OP_ACC, d, w, pick_charge(), RIDX_W'($urandom), RIDX_W'($urandom));
        issue(OP_READ, POS_W'($urandom), POS_W'($urandom), CHG_W'($urandom),
              RIDX_W'(key / IMG_WIDTH), RIDX_W'(key % IMG_WIDTH));
    endtask

    // Main sequence
    initial
    begin
        logic [POS_W-1:0] lo24, hi24, wlo24, whi24;
        int               dl, wl;
        sb         = new();
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        start      <= 1'b0;
        operation  <= OP_CLEAR;
        hit_drift  <= '0;
        hit_zpos   <= '0;
        hit_charge <= '0;
        read_row   <= '0;
        read_col   <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bin edges, extremes, every operation, at reset registers
        issue(OP_READ, '0, '0, '0, 8'd0, 8'd0);
        issue(OP_ACC, 24'd0, 24'd0, 24'hFFFFFF, 8'd0, 8'd0);
        issue(OP_READ, '0, '0, '0, 8'd0, 8'd0);
        issue(OP_ACC, -24'sd64, 24'd0, 24'd5, 8'd0, 8'd0);
        issue(OP_ACC, -24'sd65, 24'd0, 24'd5, 8'd0, 8'd0);
        issue(OP_ACC, 24'd65599, 24'd262203, 24'h800000, 8'd0, 8'd0);
        issue(OP_ACC, 24'd65600, 24'd0, 24'd7, 8'd0, 8'd0);
        issue(OP_ACC, 24'd0, 24'd262204, 24'd7, 8'd0, 8'd0);
        issue(OP_ACC, 24'h800000, 24'h800000, 24'd1, 8'd0, 8'd0);
        issue(OP_ACC, 24'h7FFFFF, 24'h7FFFFF, 24'd1, 8'd0, 8'd0);
        issue(OP_NONE, '1, '1, '1, '1, '1);
        issue(OP_READ, '0, '0, '0, 8'd255, 8'd255);
        issue(OP_ACC, 24'd3000, 24'd100, 24'd0, 8'd0, 8'd0);
        issue(OP_READ, '0, '0, '0, 8'd0, 8'd11);
        issue(OP_CLEAR, '1, '1, '1, '1, '1);
        issue(OP_READ, '0, '0, '0, 8'd255, 8'd255);
        issue(OP_READ, '0, '0, '0, 8'd0, 8'd0);

        // Directed: range filter, which spares wire positions below the low edge
        settle();
        write_reg(REG_FILTER, 32'd1);
        issue(OP_ACC, -24'sd1, 24'd0, 24'd9, 8'd0, 8'd0);
        issue(OP_ACC, 24'd0, 24'd262145, 24'd9, 8'd0, 8'd0);
        issue(OP_ACC, 24'd0, -24'sd10, 24'd9, 8'd0, 8'd0);
        issue(OP_READ, '0, '0, '0, 8'd0, 8'd0);

        // Directed: zero span, then negative span, on the drift axis
        settle();
        write_reg(REG_FILTER, 32'd0);
        write_reg(REG_DRIFT_STEP, 32'd0);
        write_reg(REG_DRIFT_HIGH, 32'd0);
        issue(OP_ACC, 24'd0, 24'd0, 24'd3, 8'd0, 8'd0);
        settle();
        write_reg(REG_DRIFT_HIGH, -32'sd50);
        issue(OP_ACC, 24'd0, 24'd0, 24'd3, 8'd0, 8'd0);

        // Reset registers, no idling, plus a saturating pixel
        settle();
        set_region(32'd0, 32'd65536, 32'd0, 32'd262144, 32'd128, 32'd119, 32'd0);
        run_random(150, 0);
        saturate_pixel();
        run_random(150, 0);

        // Widest region, full drift step, zero wire pitch, filter on
        settle();
        set_region(-32'sd8388608, 32'sd8388607, -32'sd8388608, 32'sd8388607,
                   32'd65535, 32'd0, 32'd1);
        issue(OP_CLEAR, POS_W'($urandom), POS_W'($urandom), CHG_W'($urandom),
              RIDX_W'($urandom), RIDX_W'($urandom));
        run_random(280, 45);

        // Narrow region so most pixels get hit and read back
        settle();
        dl = int'($urandom_range(0, 10000)) - 5000;
        wl = int'($urandom_range(0, 10000)) - 5000;
        set_region(dl, dl + int'($urandom_range(0, 600)), wl, wl + int'($urandom_range(0, 300)),
                   $urandom_range(0, 20), $urandom_range(0, 20), 32'd0);
        issue(OP_CLEAR, POS_W'($urandom), POS_W'($urandom), CHG_W'($urandom),
              RIDX_W'($urandom), RIDX_W'($urandom));
        run_random(280, 0);

        // Random registers, span sometimes negative
        settle();
        lo24  = POS_W'($urandom);
        hi24  = ($urandom_range(0, 3) != 0) ? lo24 + POS_W'($urandom_range(0, 1 << 22))
                                            : POS_W'($urandom);
        wlo24 = POS_W'($urandom);
        whi24 = ($urandom_range(0, 3) != 0) ? wlo24 + POS_W'($urandom_range(0, 1 << 22))
                                            : POS_W'($urandom);
        set_region({{8{lo24[POS_W-1]}}, lo24}, {{8{hi24[POS_W-1]}}, hi24},
                   {{8{wlo24[POS_W-1]}}, wlo24}, {{8{whi24[POS_W-1]}}, whi24},
                   $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 1));
        issue(OP_CLEAR, POS_W'($urandom), POS_W'($urandom), CHG_W'($urandom),
              RIDX_W'($urandom), RIDX_W'($urandom));
        run_random(280, 11);

        // Drain and let the block go quiet
        settle();
        repeat (40) @(posedge clk);

        $display("Covered %0d clears, %0d accumulates (%0d dropped), %0d reads (%0d nonzero),",
                 sb.n_clear, sb.n_acc, sb.n_drop, sb.n_read, sb.n_nonzero);
        $display("%0d undefined operations, over five register settings.", sb.n_other);
        if (sb.n_fail == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Run limit: several times the slowest legal run, dominated by the clear sweeps
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
